// ===== rtl/lcdss_pkg.sv =====
// Package for the LCD set-up serial shifter: field widths, command kinds,
// register indexes, mode codes and shared types. No dependencies.
`default_nettype none

package lcdss_pkg;

  // Fixed field widths
  localparam int WORD_W      = 16;
  localparam int BITS_W      = 5;
  localparam int KIND_W      = 2;
  localparam int HALF_W      = 16;
  localparam int DELAY_W     = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 24;  // word + bits, padded to whole bytes
  localparam int IN_USER_W   = 3;   // valid + kind
  localparam int OUT_DATA_W  = 8;   // four levels, padded to a byte

  // Default for the bit-count ceiling
  localparam int MAX_BITS_DEF = 16;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LONG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 2'd2;

  // Register reset values
  localparam logic [HALF_W-1:0]  HALF_RST  = 16'd50;
  localparam logic [DELAY_W-1:0] LONG_RST  = 24'd120000;
  localparam logic [DELAY_W-1:0] SHORT_RST = 24'd30000;

  // Sequencer modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SEND  = 2'd1;
  localparam logic [1:0] MODE_DELAY = 2'd2;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [HALF_W-1:0]  half_period_ticks;
    logic [DELAY_W-1:0] long_delay_ticks;
    logic [DELAY_W-1:0] short_delay_ticks;
  } cfg_t;

  // Line levels of one result item
  typedef struct packed {
    logic ready_res;
    logic select_n;
    logic serial_data;
    logic serial_clock;
  } res_t;

  // Bit of the word at a position; positions at or above the word width read 0
  function automatic logic word_bit(input logic [WORD_W-1:0] word,
                                    input logic [BITS_W-1:0] pos);
    logic b;
    b = pos[BITS_W-1] ? 1'b0 : word[pos[BITS_W-2:0]];
    return b;
  endfunction

  // Reload value of a clock half period; zero acts as one
  function automatic logic [DELAY_W-1:0] phase_reload(input logic [HALF_W-1:0] half);
    logic [HALF_W-1:0] h;
    h = (half == '0) ? HALF_W'(1) : half;
    return DELAY_W'(h - HALF_W'(1));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcd_init_serial_shifter.sv =====
// Three-wire serial master for LCD panel set-up. Every input item is one time
// tick and may carry a command (send a word of up to MAX_BITS bits MSB first,
// or hold for the long or short delay). The block takes one item per clock
// cycle and returns one result item per input item, holding the clock, data
// and select levels after that tick plus a ready flag that tells whether a
// command on the next item is taken. The result appears in the cycle after its
// item, from a single output register; input is taken whenever that register
// is empty or drained in the same cycle, so the rate drops below one item per
// cycle only while the result side stalls. Commands offered while busy are
// dropped. Configuration writes are taken in any cycle.
// Depends on lcdss_pkg, lcdss_cfg and lcdss_core.
`default_nettype none

module lcd_init_serial_shifter #(
  parameter int MAX_BITS = lcdss_pkg::MAX_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input items
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [lcdss_pkg::IN_DATA_W-1:0]      in_tdata,  // [15:0] cmd_word, [20:16] cmd_bits
  input  wire logic [lcdss_pkg::IN_USER_W-1:0]      in_tuser,  // [0] cmd_valid, [2:1] cmd_kind
  // result items
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [lcdss_pkg::OUT_DATA_W-1:0]          out_tdata, // [0] serial_clock, [1] serial_data,
                                                               // [2] select_n, [3] ready_res
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lcdss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lcdss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lcdss_pkg::cfg_t cfg;
  lcdss_pkg::res_t res_nxt;
  lcdss_pkg::res_t res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            in_accept;

  // Take an item when the output register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  lcdss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdss_core #(
    .MAX_BITS (MAX_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_accept),
    .cmd_valid (in_tuser[0]),
    .cmd_kind  (in_tuser[2:1]),
    .cmd_word  (in_tdata[15:0]),
    .cmd_bits  (in_tdata[20:16]),
    .cfg       (cfg),
    .res_nxt   (res_nxt)
  );

  // Output register
  assign out_valid_nxt = in_accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lcdss_pkg::OUT_DATA_W - 4){1'b0}}, res_r};

endmodule

`default_nettype wire

// ===== rtl/lcdss_cfg.sv =====
// Configuration register file of the LCD set-up serial shifter.
// Depends on lcdss_pkg.
`default_nettype none

module lcdss_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lcdss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lcdss_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lcdss_pkg::cfg_t                           cfg
);

  lcdss_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;
  assign cfg       = cfg_r;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_index)
        lcdss_pkg::CFG_HALF_PERIOD:
          cfg_nxt.half_period_ticks = cfg_data[lcdss_pkg::HALF_W-1:0];
        lcdss_pkg::CFG_LONG_DELAY:
          cfg_nxt.long_delay_ticks = cfg_data[lcdss_pkg::DELAY_W-1:0];
        lcdss_pkg::CFG_SHORT_DELAY:
          cfg_nxt.short_delay_ticks = cfg_data[lcdss_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= lcdss_pkg::HALF_RST;
      cfg_r.long_delay_ticks  <= lcdss_pkg::LONG_RST;
      cfg_r.short_delay_ticks <= lcdss_pkg::SHORT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcdss_core.sv =====
// Tick sequencer of the LCD set-up serial shifter: mode, shift word, bit and
// tick counters, line levels. Advances one tick per accepted item. Depends on lcdss_pkg.
`default_nettype none

module lcdss_core #(
  parameter int MAX_BITS = lcdss_pkg::MAX_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              advance,
  input  wire logic                              cmd_valid,
  input  wire logic [lcdss_pkg::KIND_W-1:0]      cmd_kind,
  input  wire logic [lcdss_pkg::WORD_W-1:0]      cmd_word,
  input  wire logic [lcdss_pkg::BITS_W-1:0]      cmd_bits,
  input  wire lcdss_pkg::cfg_t                   cfg,
  output lcdss_pkg::res_t                        res_nxt
);

  localparam int BL_W = $clog2(MAX_BITS + 1);

  logic [1:0]                      mode_r, mode_nxt;
  logic [lcdss_pkg::WORD_W-1:0]    shift_word_r, shift_word_nxt;
  logic [BL_W-1:0]                 bits_left_r, bits_left_nxt;
  logic                            phase_high_r, phase_high_nxt;
  logic [lcdss_pkg::DELAY_W-1:0]   tick_r, tick_nxt;
  logic                            data_r, data_nxt;
  logic                            sel_r, sel_nxt;

  logic [BL_W-1:0]                 bits_load;
  logic [BL_W-1:0]                 bl_dec;
  logic [lcdss_pkg::DELAY_W-1:0]   reload;
  logic [lcdss_pkg::DELAY_W-1:0]   delay_sel;

  // Clamp the requested bit count to the ceiling
  always_comb begin
    if (32'(cmd_bits) > 32'(MAX_BITS)) begin
      bits_load = BL_W'(MAX_BITS);
    end else begin
      bits_load = BL_W'(cmd_bits);
    end
  end

  assign bl_dec    = bits_left_r - BL_W'(1);
  assign reload    = lcdss_pkg::phase_reload(cfg.half_period_ticks);
  assign delay_sel = (cmd_kind == lcdss_pkg::KIND_LONG) ? cfg.long_delay_ticks
                                                         : cfg.short_delay_ticks;

  // One tick of the sequencer
  always_comb begin
    mode_nxt       = mode_r;
    shift_word_nxt = shift_word_r;
    bits_left_nxt  = bits_left_r;
    phase_high_nxt = phase_high_r;
    tick_nxt       = tick_r;
    data_nxt       = data_r;
    sel_nxt        = sel_r;
    if (advance) begin
      case (mode_r)
        lcdss_pkg::MODE_SEND: begin
          if (tick_r != '0) begin
            tick_nxt = tick_r - lcdss_pkg::DELAY_W'(1);
          end else if (!phase_high_r) begin
            phase_high_nxt = 1'b1;
            tick_nxt       = reload;
          end else if (bl_dec != '0) begin
            // next bit, MSB first
            bits_left_nxt  = bl_dec;
            data_nxt       = lcdss_pkg::word_bit(shift_word_r,
                               lcdss_pkg::BITS_W'(bl_dec - BL_W'(1)));
            phase_high_nxt = 1'b0;
            tick_nxt       = reload;
          end else begin
            // word done: back to idle levels
            bits_left_nxt  = '0;
            data_nxt       = 1'b0;
            sel_nxt        = 1'b1;
            phase_high_nxt = 1'b1;
            tick_nxt       = '0;
            mode_nxt       = lcdss_pkg::MODE_IDLE;
          end
        end
        lcdss_pkg::MODE_DELAY: begin
          if (tick_r != '0) begin
            tick_nxt = tick_r - lcdss_pkg::DELAY_W'(1);
          end else begin
            mode_nxt = lcdss_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = lcdss_pkg::MODE_IDLE;
          if (cmd_valid) begin
            if (cmd_kind == lcdss_pkg::KIND_SEND && cmd_bits != '0) begin
              shift_word_nxt = cmd_word;
              bits_left_nxt  = bits_load;
              sel_nxt        = 1'b0;
              mode_nxt       = lcdss_pkg::MODE_SEND;
              data_nxt       = lcdss_pkg::word_bit(cmd_word,
                                 lcdss_pkg::BITS_W'(bits_load - BL_W'(1)));
              phase_high_nxt = 1'b0;
              tick_nxt       = reload;
            end else if (cmd_kind == lcdss_pkg::KIND_LONG ||
                         cmd_kind == lcdss_pkg::KIND_SHORT) begin
              // zero-length delay keeps the block idle
              if (delay_sel != '0) begin
                tick_nxt = delay_sel - lcdss_pkg::DELAY_W'(1);
                mode_nxt = lcdss_pkg::MODE_DELAY;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= lcdss_pkg::MODE_IDLE;
      shift_word_r <= '0;
      bits_left_r  <= '0;
      phase_high_r <= 1'b1;
      tick_r       <= '0;
      data_r       <= 1'b0;
      sel_r        <= 1'b1;
    end else begin
      mode_r       <= mode_nxt;
      shift_word_r <= shift_word_nxt;
      bits_left_r  <= bits_left_nxt;
      phase_high_r <= phase_high_nxt;
      tick_r       <= tick_nxt;
      data_r       <= data_nxt;
      sel_r        <= sel_nxt;
    end
  end

  // Levels after this tick's update
  assign res_nxt.serial_clock = phase_high_nxt;
  assign res_nxt.serial_data  = data_nxt;
  assign res_nxt.select_n     = sel_nxt;
  assign res_nxt.ready_res    = (mode_nxt == lcdss_pkg::MODE_IDLE);

endmodule

`default_nettype wire

// ===== rtl/lcdss_checker.sv =====
// Port-level checks for the LCD set-up serial shifter, bound to the top level.
// Depends on lcdss_pkg and lcd_init_serial_shifter.
`default_nettype none

module lcdss_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [lcdss_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Nothing is pending right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An empty output register always takes input
  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Select low means a word is on the wire, so not ready
  a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> !out_tdata[3])
    else $error("ready while select is low");

  // Ready implies idle line levels
  a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[0] && !out_tdata[1] && out_tdata[2])
    else $error("ready without idle line levels");

endmodule

bind lcd_init_serial_shifter lcdss_checker u_lcdss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
